>>> hdl/sida_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
`default_nettype none

package sida_pkg;

  localparam int unsigned DIGIT_BITS = 4;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [3:0] BCD_LIMIT   = 4'd5;
  localparam logic [3:0] BCD_ADJUST  = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic conv_last;
    logic lead_zero;
    logic negative;
    logic last_digit;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> hdl/sida_ctrl.sv
// Controller state machine: sequences load, binary-to-BCD conversion and character output.
`default_nettype none

module sida_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sida_pkg::status_t status,
  output sida_pkg::cmd_t         cmd
);

  sida_pkg::state_t state;
  sida_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sida_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      sida_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sida_pkg::ST_CONVERT;
        end
      end
      sida_pkg::ST_CONVERT: begin
        cmd.shift = 1'b1;
        if (status.conv_last) begin
          state_next = sida_pkg::ST_SKIP;
        end
      end
      sida_pkg::ST_SKIP: begin
        // drop leading zero digits one per cycle, keep at least one
        if (status.lead_zero) begin
          cmd.skip = 1'b1;
        end else if (status.negative) begin
          state_next = sida_pkg::ST_SIGN;
        end else begin
          state_next = sida_pkg::ST_DIGITS;
        end
      end
      sida_pkg::ST_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = sida_pkg::ST_DIGITS;
        end
      end
      sida_pkg::ST_DIGITS: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.last_digit) begin
            state_next = sida_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = sida_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/sida_dp.sv
// Datapath: magnitude, shift-and-add-3 BCD register, digit counter and output register.
`default_nettype none

module sida_dp #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  input  wire sida_pkg::cmd_t                cmd,
  output sida_pkg::status_t                  status,
  output logic [7:0]                         character,
  output logic                               last,
  output logic                               out_valid,
  input  wire logic                          out_ready
);

  // decimal digits needed for any value below 2^VALUE_WIDTH
  localparam int unsigned NDIG   = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int unsigned BCDW   = NDIG * sida_pkg::DIGIT_BITS;
  localparam int unsigned BCW    = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned DCW    = $clog2(NDIG + 1);

  logic [VALUE_WIDTH-1:0] mag;
  logic [BCDW-1:0]        bcd;
  logic [BCDW-1:0]        bcd_adj;
  logic                   neg;
  logic [BCW-1:0]         bit_cnt;
  logic [DCW-1:0]         dig_cnt;
  logic [3:0]             top_digit;

  assign top_digit = bcd[BCDW-1 -: sida_pkg::DIGIT_BITS];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*sida_pkg::DIGIT_BITS +: sida_pkg::DIGIT_BITS] >= sida_pkg::BCD_LIMIT) begin
        bcd_adj[i*sida_pkg::DIGIT_BITS +: sida_pkg::DIGIT_BITS] =
          bcd[i*sida_pkg::DIGIT_BITS +: sida_pkg::DIGIT_BITS] + sida_pkg::BCD_ADJUST;
      end else begin
        bcd_adj[i*sida_pkg::DIGIT_BITS +: sida_pkg::DIGIT_BITS] =
          bcd[i*sida_pkg::DIGIT_BITS +: sida_pkg::DIGIT_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[VALUE_WIDTH-1];
      mag <= value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
      bcd <= '0;
    end else if (cmd.shift) begin
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
      bcd <= {bcd_adj[BCDW-2:0], mag[VALUE_WIDTH-1]};
    end else if (cmd.skip || cmd.emit_digit) begin
      bcd <= {bcd[BCDW-sida_pkg::DIGIT_BITS-1:0], {sida_pkg::DIGIT_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
      dig_cnt <= '0;
    end else begin
      if (cmd.load) begin
        bit_cnt <= BCW'(VALUE_WIDTH);
      end else if (cmd.shift) begin
        bit_cnt <= bit_cnt - BCW'(1);
      end
      if (cmd.load) begin
        dig_cnt <= DCW'(NDIG);
      end else if (cmd.skip || cmd.emit_digit) begin
        dig_cnt <= dig_cnt - DCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      character <= sida_pkg::CHAR_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= sida_pkg::CHAR_ZERO + {4'd0, top_digit};
      last      <= (dig_cnt == DCW'(1));
    end
  end

  assign status.conv_last  = (bit_cnt == BCW'(1));
  assign status.lead_zero  = (top_digit == 4'd0) && (dig_cnt > DCW'(1));
  assign status.negative   = neg;
  assign status.last_digit = (dig_cnt == DCW'(1));
  assign status.out_free   = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.shift, cmd.skip, cmd.emit_sign, cmd.emit_digit}))
    else $error("more than one datapath command at once");
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |-> (!out_valid || out_ready))
    else $error("character written over a waiting one");
  a_digit_left: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_digit || cmd.skip) |-> (dig_cnt != '0))
    else $error("digit taken with none left");
  a_sign_neg: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_sign |-> neg)
    else $error("sign sent for a non-negative value");
`endif

endmodule

`default_nettype wire

>>> hdl/signed_int_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII text, one character per output item.
//
//  channel  | handshake            | payload          | dir
//  ---------+----------------------+------------------+----
//  input    | in_valid / in_ready  | value            | in
//  output   | out_valid / out_ready| character, last  | out
//
// An item passes through a load, the shift-and-add-3 conversion of all VALUE_WIDTH
// bits, the dropping of leading zeros one at a time, and the output of each
// character, with a minus sign first for a negative value.
// Reset (rst, synchronous) returns the controller to idle and empties the
// output register. A stalled output holds the sequencer in place; a new item
// is taken while the final character of the previous one still waits.
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         character,
  output logic                               last
);

  sida_pkg::cmd_t    cmd;
  sida_pkg::status_t status;

  // sequence load, conversion, zero skipping and character output
  sida_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // hold magnitude, BCD digits and the output register
  sida_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .character (character),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

`default_nettype wire

>>> dv/signed_int_to_decimal_ascii_tb.sv
// Testbench for the signed integer to decimal ASCII converter: directed table plus random items.
`default_nettype none

module signed_int_to_decimal_ascii_tb;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int RANDOM_ITEMS = 148;
  // Longest quiet stretch in a correct run is roughly a send gap, a full
  // conversion and an output stall; allow many times that.
  localparam int STALL_LIMIT = 2000;
  // Tail wait after the last character: one full conversion and then some.
  localparam int DRAIN_CYCLES = 80;
  localparam int DIR_ROWS = 22;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          out_valid;
  logic                          out_ready;
  logic [7:0]                    character;
  logic                          last;

  // Characters still owed by the block, oldest first.
  text_char_t pending_chars[$];
  // Hand-written text for each presented item; empty means use the predictor.
  string      typed_text[$];
  int         mismatches;
  // When set, neither side idles: back-to-back items and results.
  logic       no_idle;

  // Directed table: extremes, zero, sign edges, digit-count boundaries,
  // alternating bit patterns. Text is typed only where obvious.
  logic [31:0] dir_value [DIR_ROWS] = '{
    32'd0,          32'd1,          32'hFFFF_FFFF,  32'd9,
    32'd10,         32'hFFFF_FFF6,  32'd99,         32'd100,
    32'hFFFF_FF9C,  32'd12345,      32'd999999999,  32'd1000000000,
    32'hC465_3600,  32'h7FFF_FFFF,  32'h8000_0000,  32'h8000_0001,
    32'h7FFF_FFFE,  32'h5555_5555,  32'hAAAA_AAAA,  32'hFFFF_FFFE,
    32'd7,          32'd1000000009
  };
  string dir_text [DIR_ROWS] = '{
    "0",            "1",            "-1",           "",
    "",             "",             "",             "",
    "",             "",             "",             "1000000000",
    "-1000000000",  "2147483647",   "-2147483648",  "-2147483647",
    "",             "",             "",             "",
    "",             ""
  };

  signed_int_to_decimal_ascii #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .character(character),
    .last     (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Queue the characters of a literal string, flagging the final one.
  function automatic void push_text(input string txt);
    text_char_t c;
    for (int i = 0; i < txt.len(); i++) begin
      c.ch   = txt[i];
      c.last = (i == txt.len() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // Predict the decimal text of one integer: optional minus sign, then digits
  // most significant first, no leading zeros, a lone '0' for zero.
  function automatic void push_decimal(input logic [VALUE_WIDTH-1:0] raw);
    logic [VALUE_WIDTH-1:0] mag;
    logic [7:0]             digits[$];
    text_char_t             c;
    // Unsigned negate: the most negative value maps onto itself, which is
    // the correct magnitude.
    mag = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
    do begin
      digits.push_front(sida_pkg::CHAR_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (raw[VALUE_WIDTH-1]) begin
      c.ch   = sida_pkg::CHAR_MINUS;
      c.last = 1'b0;
      pending_chars.push_back(c);
    end
    for (int i = 0; i < digits.size(); i++) begin
      c.ch   = digits[i];
      c.last = (i == digits.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // Present one item after an optional idle gap, hold it until taken, and return at
  // the falling edge that follows acceptance.
  task automatic send_value(input logic [31:0] v, input string txt);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    typed_text.push_back(txt);
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Draw one random value, weighted toward digit-count and sign boundaries.
  function automatic logic [31:0] random_value();
    logic [31:0] v;
    logic [31:0] pow;
    case ($urandom_range(0, 9)) inside
      [0:3]: v = $urandom;
      [4:5]: v = $urandom_range(0, 999);
      [6:7]: begin
        pow = 32'd1;
        repeat ($urandom_range(0, 9)) pow = pow * 10;
        v = pow + 32'($urandom_range(0, 2)) - 32'd1;
      end
      8: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - 32'($urandom_range(0, 3))
                                  : 32'h8000_0000 + 32'($urandom_range(0, 3));
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    // Flip the sign on half of the draws that are not already negative.
    if (v[31] == 1'b0 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // Scoreboard: predict on input acceptance, compare on output acceptance.
  always @(posedge clk) begin
    string      txt;
    text_char_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        txt = typed_text.pop_front();
        if (txt.len() != 0) push_text(txt);
        else push_decimal(value);
      end
      if (out_valid && out_ready) begin
        if (pending_chars.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected character %h last %b with nothing pending", character, last);
          mismatches++;
        end else begin
          want = pending_chars.pop_front();
          if (character !== want.ch || last !== want.last) begin
            if (mismatches < 10)
              $display("mismatch: expected char %h last %b, got char %h last %b",
                       want.ch, want.last, character, last);
            mismatches++;
          end
        end
      end
    end
  end

  // Output side: stall a random number of cycles before each character,
  // then hold ready until one is taken.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Main sequence: reset, directed table, random items, drain.
  initial begin
    int burst_left;
    rst        = 1'b1;
    in_valid   = 1'b0;
    value      = '0;
    mismatches = 0;
    no_idle    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Nothing may leave the block right after reset.
    if (out_valid !== 1'b0) begin
      $display("out_valid is %b after reset, expected 0", out_valid);
      mismatches++;
    end

    // Run the first rows back to back, then with random gaps.
    for (int i = 0; i < DIR_ROWS; i++) begin
      no_idle = (i < 6);
      send_value(dir_value[i], dir_text[i]);
    end

    // Alternate stretches of no idling with randomly gapped stretches.
    burst_left = 0;
    no_idle    = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (burst_left == 0) begin
        no_idle    = ($urandom_range(0, 3) == 0);
        burst_left = $urandom_range(5, 25);
      end
      burst_left--;
      send_value(random_value(), "");
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed character, then watch for stray output.
    while (pending_chars.size() != 0 || typed_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
